FILE: design/altl_pkg.sv
`default_nettype none
package altl_pkg;

   localparam int ADDR_W = 32;
   localparam int LINE_W = 32;
   localparam int STATUS_W = 3;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_UPDATED  = 3'd1,
      ST_FULL     = 3'd2,
      ST_FOUND    = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   localparam logic KIND_ENTER  = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] code_address;
      logic [LINE_W-1:0] line_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [LINE_W-1:0]   found_line;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH_RD,
      S_SEARCH_CMP,
      S_DECIDE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PUT,
      S_LINE_RD,
      S_LINE_WAIT,
      S_RESULT
   } state_type;

endpackage
`default_nettype wire

FILE: design/altl_if.sv
`default_nettype none
interface altl_req_if;
   import altl_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface altl_rsp_if;
   import altl_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: design/altl_store.sv
`default_nettype none
// one table column: one write port, one registered read port
module altl_store #(
   parameter int DEPTH = 1024,
   parameter int IDX_W = 10
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [IDX_W-1:0]          wr_idx,
   input  wire logic [altl_pkg::ADDR_W-1:0] wr_data,
   input  wire logic [IDX_W-1:0]          rd_idx,
   output logic      [altl_pkg::ADDR_W-1:0] rd_data
);
   import altl_pkg::*;

   logic [ADDR_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data <= mem[rd_idx];
   end
endmodule
`default_nettype wire

FILE: design/address_line_table_lookup.sv
`default_nettype none
// channel   | dir | contents
// req_      | in  | kind, code_address, line_value
// rsp_      | out | status, found_line
//
// one request at a time; a lookup runs a binary search, each probe a read of entry mid
// and a compare once the registered read returns, then reads the line of the entry found
// an enter takes the search, then a read and a write per entry moved up by an insert
// (single read and single write port on each column)
// synchronous reset clears the entry count and control; the columns are not cleared
// the result stays in the output register until taken; the next request is
// accepted once it has gone
module address_line_table_lookup #(
   parameter int TABLE_ENTRIES = 1024
) (
   input wire logic clock,
   input wire logic reset,
   altl_req_if.sink   req,
   altl_rsp_if.source rsp
);
   import altl_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

   state_type state_ff, state_in;
   req_type   item_ff, item_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;    // shift pointer: slot that the entry below is moved into
   rsp_type   out_ff, out_in;
   logic      out_valid_ff, out_valid_in;

   // column ports
   logic              a_we, l_we;
   logic [IDX_W-1:0]  a_widx, l_widx, a_ridx, l_ridx;
   logic [ADDR_W-1:0] a_wdata, a_rdata;
   logic [LINE_W-1:0] l_wdata, l_rdata;

   altl_store #(.DEPTH(TABLE_ENTRIES), .IDX_W(IDX_W)) u_addr (
      .clock, .wr_en(a_we), .wr_idx(a_widx), .wr_data(a_wdata),
      .rd_idx(a_ridx), .rd_data(a_rdata));
   altl_store #(.DEPTH(TABLE_ENTRIES), .IDX_W(IDX_W)) u_line (
      .clock, .wr_en(l_we), .wr_idx(l_widx), .wr_data(l_wdata),
      .rd_idx(l_ridx), .rd_data(l_rdata));

   logic [CNT_W-1:0] mid;
   logic [CNT_W:0]   mid_sum;
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CNT_W:1];

   assign req.ready   = (state_ff == S_IDLE) && !out_valid_ff;
   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:       if (req.valid && req.ready) state_in = S_SEARCH_RD;
         S_SEARCH_RD:  state_in = (lo_ff < hi_ff) ? S_SEARCH_CMP : S_DECIDE;
         S_SEARCH_CMP: state_in = S_SEARCH_RD;
         S_DECIDE: begin
            // lo_ff is the count of entries below the key; a_rdata holds entry lo
            if (item_ff.kind == KIND_LOOKUP) begin
               state_in = (count_ff == '0) ? S_RESULT : S_LINE_RD;
            end else if (lo_ff < count_ff && a_rdata == item_ff.code_address) begin
               state_in = S_RESULT;
            end else if (count_ff == FULL_COUNT) begin
               state_in = S_RESULT;
            end else if (count_ff > lo_ff) begin
               state_in = S_SHIFT_RD;
            end else begin
               state_in = S_PUT;
            end
         end
         S_SHIFT_RD:  state_in = S_SHIFT_WR;
         // last move is entry lo into lo+1
         S_SHIFT_WR:  state_in = (ptr_ff == lo_ff + 1'b1) ? S_PUT : S_SHIFT_RD;
         S_PUT:       state_in = S_RESULT;
         S_LINE_RD:   state_in = S_LINE_WAIT;
         S_LINE_WAIT: state_in = S_RESULT;
         S_RESULT:    state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      item_in      = item_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      ptr_in       = ptr_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      a_we = 1'b0; l_we = 1'b0;
      a_widx = IDX_W'(ptr_ff); l_widx = IDX_W'(ptr_ff);
      a_wdata = a_rdata; l_wdata = l_rdata;
      a_ridx = IDX_W'(mid); l_ridx = IDX_W'(mid);
      if (out_valid_ff && rsp.ready) out_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               item_in = req.payload;
               lo_in   = '0;
               hi_in   = count_ff;
            end
         end
         S_SEARCH_RD: begin
            // read mid while searching, entry lo when done
            if (!(lo_ff < hi_ff)) begin
               a_ridx = IDX_W'(lo_ff);
               l_ridx = IDX_W'(lo_ff);
            end
         end
         S_SEARCH_CMP: begin
            if (a_rdata < item_ff.code_address) lo_in = mid + 1'b1;
            else hi_in = mid;
         end
         S_DECIDE: begin
            out_in.found_line = '0;
            ptr_in = count_ff;
            if (item_ff.kind == KIND_LOOKUP) begin
               out_in.status = (count_ff == '0) ? ST_EMPTY : ST_FOUND;
            end else if (lo_ff < count_ff && a_rdata == item_ff.code_address) begin
               l_we = 1'b1;
               l_widx = IDX_W'(lo_ff);
               l_wdata = item_ff.line_value;
               out_in.status = ST_UPDATED;
            end else if (count_ff == FULL_COUNT) begin
               out_in.status = ST_FULL;
            end else begin
               out_in.status = ST_INSERTED;
            end
         end
         S_SHIFT_RD: begin
            // fetch entry ptr-1 to move up into ptr
            a_ridx = IDX_W'(ptr_ff - 1'b1);
            l_ridx = IDX_W'(ptr_ff - 1'b1);
         end
         S_SHIFT_WR: begin
            a_we = 1'b1; l_we = 1'b1;
            ptr_in = ptr_ff - 1'b1;
         end
         S_PUT: begin
            a_we = 1'b1; l_we = 1'b1;
            a_widx = IDX_W'(lo_ff); l_widx = IDX_W'(lo_ff);
            a_wdata = item_ff.code_address;
            l_wdata = item_ff.line_value;
            count_in = count_ff + 1'b1;
         end
         S_LINE_RD: begin
            a_ridx = IDX_W'((lo_ff != '0) ? lo_ff - 1'b1 : lo_ff);
            l_ridx = a_ridx;
         end
         S_LINE_WAIT: out_in.found_line = l_rdata;
         S_RESULT:    out_valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      item_ff <= item_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      ptr_ff  <= ptr_in;
      out_ff  <= out_in;
   end
endmodule
`default_nettype wire

FILE: design/altl_checker.sv
`default_nettype none
module altl_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [altl_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [altl_pkg::LINE_W-1:0]   rsp_found_line
);
   import altl_pkg::*;

   // a result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped or changed");
   // no request taken while a result waits
   a_one_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted with result pending");
   // a request is not answered in the cycle after it
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("result too early");
   // only lookups give a line
   a_line_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_FOUND |-> rsp_found_line == '0)
      else $error("line on non lookup result");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_EMPTY)
      else $error("bad status");
endmodule

bind address_line_table_lookup altl_checker u_altl_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.payload.status), .rsp_found_line(rsp.payload.found_line));
`default_nettype wire
